/* hw/rtl/lmsamp_pkg.sv */
// shared constants and types for the node load metric sampler
`timescale 1ns / 1ps

package lmsamp_pkg;

    localparam int TICKS_PER_SECOND_DEF = 128;
    localparam int TIME_WIDTH_DEF       = 32;

    localparam logic [31:0] WINDOW_RESET = 32'd3840;

    localparam int LOAD_UNIT = 128;
    localparam logic [6:0] LOAD_CAP     = 7'h7f;
    localparam logic [7:0] LOAD_UNKNOWN = 8'hff;
    localparam logic [15:0] RATE_CAP    = 16'hffff;

    // own and parent weights of the blended load, sixteenths
    localparam int W_SELF   = 5;
    localparam int W_PARENT = 11;
    localparam int W_SHIFT  = 4;
    localparam int W_ROUND  = 1 << (W_SHIFT - 1);

    // quotient bits worked out per division before it saturates
    localparam int QBITS_LOAD = 7;
    localparam int QBITS_RATE = 16;

    typedef logic [1:0] div_kind_t;
    localparam div_kind_t DIV_SELF  = 2'd0;
    localparam div_kind_t DIV_RATE  = 2'd1;
    localparam div_kind_t DIV_RATIO = 2'd2;

    typedef struct packed {
        logic      start;
        div_kind_t kind;
    } ndiv_req_t;

endpackage

/* hw/rtl/lmsamp_ndiv.sv */
// normalising bit-serial divider with saturating quotient
`timescale 1ns / 1ps

module lmsamp_ndiv #(
    parameter int TICKS_PER_SECOND = lmsamp_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lmsamp_pkg::ndiv_req_t req,
    input  logic [63:0]           num,
    input  logic [63:0]           den,
    output logic                  done,
    output logic [15:0]           quot
);

    localparam logic [31:0] SELF_SCALE = 32'(lmsamp_pkg::LOAD_UNIT);
    localparam logic [31:0] RATE_SCALE = 32'(lmsamp_pkg::LOAD_UNIT * TICKS_PER_SECOND);
    localparam logic [63:0] SELF_NUM_MAX = 64'hffff_ffff / 64'(SELF_SCALE);
    localparam logic [63:0] RATE_NUM_MAX = 64'hffff_ffff / 64'(RATE_SCALE);
    localparam logic [63:0] WORD_MAX     = 64'hffff_ffff;

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_NORM = 3'd1;
    localparam logic [2:0] D_MUL  = 3'd2;
    localparam logic [2:0] D_CHK  = 3'd3;
    localparam logic [2:0] D_ITER = 3'd4;

    logic [2:0]                  state_reg, state_next;
    lmsamp_pkg::div_kind_t       kind_reg, kind_next;
    logic [63:0]                 num_reg, num_next;
    logic [63:0]                 den_reg, den_next;
    logic [31:0]                 dvd_reg, dvd_next;
    logic [31:0]                 rem_reg, rem_next;
    logic [15:0]                 quot_reg, quot_next;
    logic [3:0]                  cnt_reg, cnt_next;
    logic                        done_reg, done_next;

    logic [63:0] num_max;
    logic [31:0] scale;
    logic        wide_q;
    logic [31:0] hi_part;
    logic [32:0] trial;
    logic        qbit;

    always_comb begin
        case (kind_reg)
            lmsamp_pkg::DIV_SELF: begin
                num_max = SELF_NUM_MAX;
                scale   = SELF_SCALE;
            end
            lmsamp_pkg::DIV_RATE: begin
                num_max = RATE_NUM_MAX;
                scale   = RATE_SCALE;
            end
            default: begin
                num_max = WORD_MAX;
                scale   = 32'd1;
            end
        endcase
    end

    assign wide_q  = (kind_reg == lmsamp_pkg::DIV_RATE);
    assign hi_part = wide_q ? (dvd_reg >> lmsamp_pkg::QBITS_RATE)
                            : (dvd_reg >> lmsamp_pkg::QBITS_LOAD);
    assign trial   = {rem_reg, dvd_reg[31]};
    assign qbit    = (trial >= {1'b0, den_reg[31:0]});

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE: begin
                if (req.start) begin
                    kind_next  = req.kind;
                    num_next   = num;
                    den_next   = den;
                    state_next = D_NORM;
                end
            end
            D_NORM: begin
                // shift both together until num * scale and den fit one word
                if (num_reg > num_max || den_reg[63:32] != 32'd0) begin
                    num_next = num_reg >> 1;
                    den_next = den_reg >> 1;
                end else begin
                    state_next = D_MUL;
                end
            end
            D_MUL: begin
                dvd_next   = num_reg[31:0] * scale;
                state_next = D_CHK;
            end
            D_CHK: begin
                // quotient too big for its bits, or den gone to zero: saturate
                if (hi_part >= den_reg[31:0]) begin
                    quot_next  = wide_q ? lmsamp_pkg::RATE_CAP
                                        : 16'(lmsamp_pkg::LOAD_CAP);
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end else begin
                    rem_next   = hi_part;
                    dvd_next   = wide_q ? (dvd_reg << (32 - lmsamp_pkg::QBITS_RATE))
                                        : (dvd_reg << (32 - lmsamp_pkg::QBITS_LOAD));
                    cnt_next   = wide_q ? 4'(lmsamp_pkg::QBITS_RATE - 1)
                                        : 4'(lmsamp_pkg::QBITS_LOAD - 1);
                    quot_next  = 16'd0;
                    state_next = D_ITER;
                end
            end
            D_ITER: begin
                rem_next  = qbit ? 32'(trial - {1'b0, den_reg[31:0]}) : trial[31:0];
                quot_next = {quot_reg[14:0], qbit};
                dvd_next  = {dvd_reg[30:0], 1'b0};
                cnt_next  = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0) begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        kind_reg <= kind_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* hw/rtl/node_load_metric_sampler.sv */
// top level of the node load metric sampler
//
// one sample beat in on s_*, one result beat out on m_* for every sample.
// the sample carries time, cpu and total tick counters, tx and drop counters,
// root and parent flags and the parent's advertised load; the block keeps the
// previous counters and reports own load, blended load, packet rate and drop
// ratio. cfg_wr_en writes traffic_window_ticks; write it only
// while no sample is in flight.
// a sample's time from accept to result valid is set by the one shared
// divider: its normalising shift moves one bit a cycle (up to 39 bits for
// cpu load, up to 14 for packet rate), then one multiply, one saturation
// check and one quotient bit a cycle (7 for loads and drop ratio, 16 for
// packet rate). root or an unexpired window skip the traffic divisions.
// s_ready is high only while no sample is in work; a finished result sits in
// the output register, and a stalled receiver holds the next result back.
// reset clears the counters, held rate and ratio and sets the window to 3840.
`timescale 1ns / 1ps

module node_load_metric_sampler #(
    parameter int TICKS_PER_SECOND = lmsamp_pkg::TICKS_PER_SECOND_DEF,
    parameter int TIME_WIDTH       = lmsamp_pkg::TIME_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_now_ticks,
    input  logic [63:0] s_cpu_ticks,
    input  logic [63:0] s_total_ticks,
    input  logic [31:0] s_tx_count,
    input  logic [31:0] s_drop_count,
    input  logic        s_is_root,
    input  logic        s_parent_present,
    input  logic [7:0]  s_parent_load,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_self_load,
    output logic [6:0]  m_blended_load,
    output logic [15:0] m_packet_rate,
    output logic [6:0]  m_drop_ratio
);

    // the time field is 32 bits, so the wrap width never exceeds it
    localparam int TW = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_SELF       = 3'd1;
    localparam logic [2:0] ST_SELF_WAIT  = 3'd2;
    localparam logic [2:0] ST_TRAF       = 3'd3;
    localparam logic [2:0] ST_RATE_WAIT  = 3'd4;
    localparam logic [2:0] ST_RATIO      = 3'd5;
    localparam logic [2:0] ST_RATIO_WAIT = 3'd6;
    localparam logic [2:0] ST_OUT        = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [31:0]   window_reg, window_next;
    logic [63:0]   prev_cpu_reg, prev_cpu_next;
    logic [63:0]   prev_total_reg, prev_total_next;
    logic [TW-1:0] prev_time_reg, prev_time_next;
    logic [31:0]   prev_tx_reg, prev_tx_next;
    logic [31:0]   prev_drops_reg, prev_drops_next;
    logic [15:0]   held_rate_reg, held_rate_next;
    logic [6:0]    held_ratio_reg, held_ratio_next;

    // sample captured at accept
    logic [63:0]   dcpu_reg, dcpu_next;
    logic [63:0]   dtot_reg, dtot_next;
    logic [TW-1:0] now_reg, now_next;
    logic [31:0]   tx_reg, tx_next;
    logic [31:0]   drops_reg, drops_next;
    logic          root_reg, root_next;
    logic          parent_reg, parent_next;
    logic [7:0]    pload_reg, pload_next;

    logic [6:0]    self_reg, self_next;
    logic [6:0]    blend_reg, blend_next;
    logic [31:0]   dtx_reg, dtx_next;
    logic [31:0]   ddr_reg, ddr_next;

    logic          m_valid_reg, m_valid_next;
    logic [6:0]    m_self_reg, m_self_next;
    logic [6:0]    m_blend_reg, m_blend_next;
    logic [15:0]   m_rate_reg, m_rate_next;
    logic [6:0]    m_ratio_reg, m_ratio_next;

    lmsamp_pkg::ndiv_req_t div_req;
    logic [63:0]           div_num;
    logic [63:0]           div_den;
    logic                  div_done;
    logic [15:0]           div_quot;

    logic          in_beat;
    logic          out_load;
    logic [TW-1:0] dt_comb;
    logic [31:0]   dtx_comb;
    logic [31:0]   ddr_comb;
    logic [11:0]   mix;
    logic [6:0]    mix_load;

    assign in_beat  = s_valid && s_ready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign dt_comb  = now_reg - prev_time_reg;
    assign dtx_comb = tx_reg - prev_tx_reg;
    assign ddr_comb = drops_reg - prev_drops_reg;

    // (5 * own + 11 * parent + 8) >> 4, capped
    assign mix = 12'(lmsamp_pkg::W_SELF) * {5'd0, self_reg}
               + 12'(lmsamp_pkg::W_PARENT) * {4'd0, pload_reg}
               + 12'(lmsamp_pkg::W_ROUND);
    assign mix_load = (mix[11:lmsamp_pkg::W_SHIFT] > {1'b0, lmsamp_pkg::LOAD_CAP})
                    ? lmsamp_pkg::LOAD_CAP : mix[10:lmsamp_pkg::W_SHIFT];

    always_comb begin
        div_req.start = 1'b0;
        div_req.kind  = lmsamp_pkg::DIV_RATIO;
        div_num       = 64'(dtx_reg);
        div_den       = 64'(ddr_reg);
        case (state_reg)
            ST_SELF: begin
                div_req.start = (dtot_reg != 64'd0);
                div_req.kind  = lmsamp_pkg::DIV_SELF;
                div_num       = dcpu_reg;
                div_den       = dtot_reg;
            end
            ST_TRAF: begin
                div_req.start = !root_reg && (32'(dt_comb) > window_reg);
                div_req.kind  = lmsamp_pkg::DIV_RATE;
                div_num       = 64'(dtx_comb);
                div_den       = 64'(dt_comb);
            end
            ST_RATIO: begin
                div_req.start = 1'b1;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    lmsamp_ndiv #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quot   (div_quot)
    );

    always_comb begin
        state_next      = state_reg;
        window_next     = cfg_wr_en ? cfg_wr_data : window_reg;
        prev_cpu_next   = prev_cpu_reg;
        prev_total_next = prev_total_reg;
        prev_time_next  = prev_time_reg;
        prev_tx_next    = prev_tx_reg;
        prev_drops_next = prev_drops_reg;
        held_rate_next  = held_rate_reg;
        held_ratio_next = held_ratio_reg;
        dcpu_next       = dcpu_reg;
        dtot_next       = dtot_reg;
        now_next        = now_reg;
        tx_next         = tx_reg;
        drops_next      = drops_reg;
        root_next       = root_reg;
        parent_next     = parent_reg;
        pload_next      = pload_reg;
        self_next       = self_reg;
        blend_next      = blend_reg;
        dtx_next        = dtx_reg;
        ddr_next        = ddr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_self_next     = m_self_reg;
        m_blend_next    = m_blend_reg;
        m_rate_next     = m_rate_reg;
        m_ratio_next    = m_ratio_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    dcpu_next       = s_cpu_ticks - prev_cpu_reg;
                    dtot_next       = s_total_ticks - prev_total_reg;
                    prev_cpu_next   = s_cpu_ticks;
                    prev_total_next = s_total_ticks;
                    now_next        = s_now_ticks[TW-1:0];
                    tx_next         = s_tx_count;
                    drops_next      = s_drop_count;
                    root_next       = s_is_root;
                    parent_next     = s_parent_present;
                    pload_next      = s_parent_load;
                    state_next      = ST_SELF;
                end
            end
            ST_SELF: begin
                if (dtot_reg == 64'd0) begin
                    self_next  = 7'd0;
                    state_next = ST_TRAF;
                end else begin
                    state_next = ST_SELF_WAIT;
                end
            end
            ST_SELF_WAIT: begin
                if (div_done) begin
                    self_next  = div_quot[6:0];
                    state_next = ST_TRAF;
                end
            end
            ST_TRAF: begin
                if (root_reg) begin
                    blend_next = 7'd0;
                end else if (!parent_reg || pload_reg == lmsamp_pkg::LOAD_UNKNOWN) begin
                    blend_next = self_reg;
                end else begin
                    blend_next = mix_load;
                end
                // window passed: recompute traffic figures and move the marks
                if (div_req.start) begin
                    dtx_next        = dtx_comb;
                    ddr_next        = ddr_comb;
                    prev_time_next  = now_reg;
                    prev_tx_next    = tx_reg;
                    prev_drops_next = drops_reg;
                    state_next      = ST_RATE_WAIT;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_RATE_WAIT: begin
                if (div_done) begin
                    held_rate_next = div_quot;
                    if (ddr_reg == 32'd0) begin
                        held_ratio_next = 7'd0;
                        state_next      = ST_OUT;
                    end else begin
                        state_next = ST_RATIO;
                    end
                end
            end
            ST_RATIO: begin
                state_next = ST_RATIO_WAIT;
            end
            ST_RATIO_WAIT: begin
                if (div_done) begin
                    held_ratio_next = div_quot[6:0];
                    state_next      = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_self_next  = self_reg;
                    m_blend_next = blend_reg;
                    m_rate_next  = root_reg ? 16'd0 : held_rate_reg;
                    m_ratio_next = root_reg ? 7'd0 : held_ratio_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            window_reg     <= lmsamp_pkg::WINDOW_RESET;
            prev_cpu_reg   <= 64'd0;
            prev_total_reg <= 64'd0;
            prev_time_reg  <= '0;
            prev_tx_reg    <= 32'd0;
            prev_drops_reg <= 32'd0;
            held_rate_reg  <= 16'd0;
            held_ratio_reg <= 7'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            window_reg     <= window_next;
            prev_cpu_reg   <= prev_cpu_next;
            prev_total_reg <= prev_total_next;
            prev_time_reg  <= prev_time_next;
            prev_tx_reg    <= prev_tx_next;
            prev_drops_reg <= prev_drops_next;
            held_rate_reg  <= held_rate_next;
            held_ratio_reg <= held_ratio_next;
            m_valid_reg    <= m_valid_next;
        end
        dcpu_reg    <= dcpu_next;
        dtot_reg    <= dtot_next;
        now_reg     <= now_next;
        tx_reg      <= tx_next;
        drops_reg   <= drops_next;
        root_reg    <= root_next;
        parent_reg  <= parent_next;
        pload_reg   <= pload_next;
        self_reg    <= self_next;
        blend_reg   <= blend_next;
        dtx_reg     <= dtx_next;
        ddr_reg     <= ddr_next;
        m_self_reg  <= m_self_next;
        m_blend_reg <= m_blend_next;
        m_rate_reg  <= m_rate_next;
        m_ratio_reg <= m_ratio_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_self_load    = m_self_reg;
    assign m_blended_load = m_blend_reg;
    assign m_packet_rate  = m_rate_reg;
    assign m_drop_ratio   = m_ratio_reg;

    // no second sample is taken while one is in work
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !s_ready)
        else $error("sample accepted while previous one still in work");

    // divider results only arrive while the sequencer waits for them
    a_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_SELF_WAIT || state_reg == ST_RATE_WAIT
                      || state_reg == ST_RATIO_WAIT))
        else $error("divider finished with nobody waiting");

    // load quotients saturate at seven bits
    a_load_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_done && (state_reg == ST_SELF_WAIT || state_reg == ST_RATIO_WAIT))
        |-> (div_quot[15:7] == 9'd0))
        else $error("load quotient wider than seven bits");

    // at the root the blended load and traffic figures go out as zero
    a_root_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && root_reg) |=> (m_blended_load == 7'd0 && m_packet_rate == 16'd0
                                    && m_drop_ratio == 7'd0))
        else $error("root result with nonzero traffic figures");

endmodule
